// File: hw/rtl/mrhs_pkg.sv
`timescale 1ns / 1ps
package mrhs_pkg;
  localparam int MaxLen = 1024;
  localparam int AddrW = $clog2(MaxLen);
  localparam int CntW = AddrW + 1;
  localparam int DblW = AddrW + 2;
  localparam logic [30:0] HashMod = 31'h7fffffff;
  localparam logic [30:0] HashBase = 31'd500000000;

  typedef struct packed {
    logic [7:0] char_value;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  start_index;
    logic [10:0] text_length;
  } out_item_t;

  // Job handed from the loader to the search engine
  typedef struct packed {
    logic [CntW-1:0] len;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BUILD_RD, S_BUILD_MUL, S_BUILD_RED, S_CAND, S_MID,
    S_RD_WAIT, S_MUL, S_RED, S_CMP, S_BYTE_RD, S_BYTE_CMP, S_DONE
  } eng_state_e;

  // Reduce a 62-bit product modulo 2^31-1
  function automatic logic [30:0] mod_fold(input logic [61:0] x);
    logic [32:0] s;
    logic [31:0] t;
    begin
      s = {2'b0, x[30:0]} + {2'b0, x[61:31]};
      t = {1'b0, s[30:0]} + {30'b0, s[32:31]};
      t = {1'b0, t[30:0]} + {31'b0, t[31]};
      mod_fold = (t[30:0] == HashMod) ? 31'd0 : t[30:0];
    end
  endfunction

  function automatic logic [30:0] mod_add(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      mod_add = (s >= {1'b0, HashMod}) ? 31'(s - {1'b0, HashMod}) : s[30:0];
    end
  endfunction
endpackage

// File: hw/rtl/minimal_rotation_by_hash_search.sv
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// input   | in  | push / full        | in_data_i  (char_value, is_final)
// result  | out | empty / pop        | out_data_o (start_index, text_length)
// A non-final byte is written to the text store. A final byte starts a search
// that builds prefix hashes and base powers, then runs a binary search per
// candidate rotation and a handoff, each step computing two window hashes
// through one product unit.
// Reset clears control only; full stays high from the final byte until the
// search ends and its result has found a free slot.
module minimal_rotation_by_hash_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  mrhs_pkg::in_item_t   in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output mrhs_pkg::out_item_t  out_data_o
);
  import mrhs_pkg::*;
  logic txt_we;
  logic [AddrW-1:0] txt_wa;
  logic [7:0] txt_wd;
  logic job_valid, job_ready, res_valid;
  job_t job;

  mrhs_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_data_i,
    .txt_we_o(txt_we), .txt_wa_o(txt_wa), .txt_wd_o(txt_wd),
    .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  mrhs_engine u_engine (
    .clk_i, .rst_ni,
    .txt_we_i(txt_we), .txt_wa_i(txt_wa), .txt_wd_i(txt_wd),
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready),
    .res_valid_o(res_valid), .res_o(out_data_o), .res_ready_i(pop)
  );

  assign empty = !res_valid;
endmodule

// File: hw/rtl/mrhs_front.sv
`timescale 1ns / 1ps
module mrhs_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  mrhs_pkg::in_item_t      in_data_i,
  output logic                    txt_we_o,
  output logic [mrhs_pkg::AddrW-1:0] txt_wa_o,
  output logic [7:0]              txt_wd_o,
  output logic                    job_valid_o,
  output mrhs_pkg::job_t          job_o,
  input  logic                    job_ready_i
);
  import mrhs_pkg::*;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic job_valid_q, job_valid_d;
  job_t job_q, job_d;
  logic acc;

  // stall input while a job waits or the engine still reads the text store
  assign full = job_valid_q || !job_ready_i;
  assign acc = push && !full;
  assign txt_we_o = acc && (cnt_q < CntW'(MaxLen));
  assign txt_wa_o = cnt_q[AddrW-1:0];
  assign txt_wd_o = in_data_i.char_value;
  assign job_valid_o = job_valid_q;
  assign job_o = job_q;

  always_comb begin
    cnt_d = cnt_q;
    job_valid_d = job_valid_q && !job_ready_i;
    job_d = job_q;
    if (acc) begin
      if (txt_we_o) cnt_d = cnt_q + 1'b1;
      if (in_data_i.is_final) begin
        job_valid_d = 1'b1;
        job_d.len = txt_we_o ? cnt_q + 1'b1 : cnt_q;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      job_valid_q <= 1'b0;
      job_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      job_valid_q <= job_valid_d;
      job_q <= job_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(MaxLen))
    else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && !job_ready_i |=> job_valid_q && $stable(job_q))
    else $error("job lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_valid_q |-> job_q.len != '0)
    else $error("empty job");
endmodule

// File: hw/rtl/mrhs_engine.sv
`timescale 1ns / 1ps
module mrhs_engine (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    txt_we_i,
  input  logic [mrhs_pkg::AddrW-1:0] txt_wa_i,
  input  logic [7:0]              txt_wd_i,
  input  logic                    job_valid_i,
  input  mrhs_pkg::job_t          job_i,
  output logic                    job_ready_o,
  output logic                    res_valid_o,
  output mrhs_pkg::out_item_t     res_o,
  input  logic                    res_ready_i
);
  import mrhs_pkg::*;
  localparam int DblDepth = 2 * MaxLen + 1;

  logic [7:0]  txt_mem [MaxLen];
  logic [30:0] h_mem [DblDepth];
  logic [30:0] p_mem [DblDepth];

  eng_state_e state_q, state_d;
  logic [CntW-1:0] n_q;
  logic [DblW-1:0] k_q;
  logic [AddrW-1:0] tpos_q;
  logic [AddrW-1:0] best_q, cand_q;
  logic [CntW-1:0] lo_q, hi_q, mid_q, com_q;
  logic [1:0] ph_q;
  logic [30:0] hprev_q, pprev_q, ha_q, hb_q, hx_q;
  logic [61:0] mh_q, mp_q;
  logic res_valid_q;
  out_item_t res_q;

  // memory ports: one write per memory; two reads each from the text and hash stores, one from the power store
  logic h_we, seed;
  logic [DblW-1:0] h_wa, ra0, ra1;
  logic [30:0] h_wd, p_wd, h_rd0, h_rd1, p_rd;
  logic [AddrW-1:0] t_ra0, t_ra1;
  logic [7:0] t_rd0, t_rd1;

  always_ff @(posedge clk_i) begin
    if (txt_we_i) txt_mem[txt_wa_i] <= txt_wd_i;
    t_rd0 <= txt_mem[t_ra0];
    t_rd1 <= txt_mem[t_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[h_wa] <= h_wd;
      p_mem[h_wa] <= p_wd;
    end
    h_rd0 <= h_mem[ra0];
    h_rd1 <= h_mem[ra1];
    p_rd  <= p_mem[DblW'(mid_q)];
  end

  // wrap helper: (a + b) mod n, a,b < n
  function automatic logic [AddrW-1:0] wrap(input logic [CntW:0] s, input logic [CntW-1:0] n);
    wrap = (s >= {1'b0, n}) ? AddrW'(s - {1'b0, n}) : AddrW'(s);
  endfunction

  // address selection: reads h[pos+mid], h[pos] and p[mid] together
  logic [AddrW-1:0] pos_sel;
  assign pos_sel = ph_q[0] ? cand_q : best_q;

  always_comb begin
    ra0 = DblW'(pos_sel) + DblW'(mid_q);
    ra1 = DblW'(pos_sel);
    t_ra0 = wrap({1'b0, CntW'(best_q)} + {1'b0, com_q}, n_q);
    t_ra1 = wrap({1'b0, CntW'(cand_q)} + {1'b0, com_q}, n_q);
    if (state_q == S_BUILD_RD || state_q == S_BUILD_MUL) begin
      t_ra0 = tpos_q;
    end
  end

  // seed entry zero of both tables when a job is taken
  assign seed = (state_q == S_IDLE) && job_valid_i;
  assign h_we = seed || (state_q == S_BUILD_RED);
  assign h_wa = seed ? '0 : k_q + 1'b1;
  assign h_wd = seed ? '0 : mod_add(mod_fold(mh_q), {23'b0, t_rd0});
  assign p_wd = seed ? 31'd1 : mod_fold(mp_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (job_valid_i) state_d = S_BUILD_RD;
      S_BUILD_RD:  state_d = S_BUILD_MUL;
      S_BUILD_MUL: state_d = S_BUILD_RED;
      S_BUILD_RED: state_d = (k_q + 1'b1 == {n_q, 1'b0}) ? S_CAND : S_BUILD_RD;
      S_CAND:      state_d = (CntW'(cand_q) >= n_q || cand_q == '0) ? S_DONE : S_MID;
      S_MID:       state_d = (lo_q <= hi_q) ? S_RD_WAIT : S_BYTE_RD;
      S_RD_WAIT:   state_d = S_MUL;
      S_MUL:       state_d = S_RED;
      S_RED:       state_d = ph_q[0] ? S_CMP : S_RD_WAIT;
      S_CMP:       state_d = S_MID;
      S_BYTE_RD:   state_d = S_BYTE_CMP;
      S_BYTE_CMP:  state_d = S_CAND;
      S_DONE:      if (!res_valid_q) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (state_q == S_IDLE);
  end

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        n_q <= job_i.len;
        k_q <= '0;
        tpos_q <= '0;
        hprev_q <= '0;
        pprev_q <= 31'd1;
        best_q <= '0;
        cand_q <= AddrW'(1);
      end
      S_BUILD_RD: ;
      S_BUILD_MUL: begin
        mh_q <= hprev_q * HashBase;
        mp_q <= pprev_q * HashBase;
      end
      S_BUILD_RED: begin
        hprev_q <= h_wd;
        pprev_q <= p_wd;
        k_q <= k_q + 1'b1;
        tpos_q <= (CntW'(tpos_q) + 1'b1 == n_q) ? '0 : tpos_q + 1'b1;
      end
      S_CAND: begin
        lo_q <= CntW'(1);
        hi_q <= n_q;
        com_q <= '0;
        ph_q <= '0;
      end
      S_MID: mid_q <= CntW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
      S_RD_WAIT: ;
      S_MUL: begin
        hx_q <= h_rd0;
        mh_q <= h_rd1 * p_rd;
      end
      S_RED: begin
        if (ph_q[0]) hb_q <= mod_add(hx_q, HashMod - mod_fold(mh_q));
        else ha_q <= mod_add(hx_q, HashMod - mod_fold(mh_q));
        ph_q <= ph_q + 1'b1;
      end
      S_CMP: begin
        ph_q <= '0;
        if (ha_q == hb_q) begin
          com_q <= mid_q;
          lo_q <= mid_q + 1'b1;
        end else begin
          hi_q <= mid_q - 1'b1;
        end
      end
      S_BYTE_RD: ;
      S_BYTE_CMP: begin
        if (t_rd0 > t_rd1) best_q <= cand_q;
        cand_q <= cand_q + 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // hold the result until taken; one result per job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q <= '0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      if (state_q == S_DONE && !res_valid_q) begin
        res_valid_q <= 1'b1;
        res_q.start_index <= 10'(best_q);
        res_q.text_length <= 11'(n_q);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MID |-> hi_q <= n_q) else $error("hi out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BYTE_CMP |-> CntW'(best_q) < n_q) else $error("best out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !res_valid_q |=> res_valid_q) else $error("result dropped");
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mrhs_pkg::*;

  localparam int unsigned StoreDepth = 1024;
  localparam longint unsigned Base = 64'd500000000;
  localparam longint unsigned Modulus = 64'd2147483647;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned NumStrings = 75;

  typedef struct {
    logic [7:0]  ch;
    logic        fin;
    bit          typed;
    logic [9:0]  exp_start;
    logic [10:0] exp_len;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_data_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_data_o;

  out_item_t   rotation_q[$];
  logic [7:0]  cur_text[$];
  longint unsigned pref_hash[0:2*StoreDepth];
  longint unsigned base_pow[0:2*StoreDepth];
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned string_cnt = 0;
  int unsigned beat_cnt = 0;
  bit          quiet = 1'b0;
  bit          typed_pending = 1'b0;
  out_item_t   typed_result;

  minimal_rotation_by_hash_search u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, rotation_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint unsigned window_of(int unsigned pos, int unsigned len);
    longint unsigned sub;
    sub = (pref_hash[pos] * base_pow[len]) % Modulus;
    return (pref_hash[pos + len] + Modulus - sub) % Modulus;
  endfunction

  // Work out the least rotation of the held string by hashed prefix search
  function automatic out_item_t least_rotation();
    int unsigned n, k, cand, lo, hi, mid, common, best;
    out_item_t res;
    n = cur_text.size();
    pref_hash[0] = 0;
    base_pow[0] = 1;
    for (k = 0; k < 2 * n; k++) begin
      pref_hash[k+1] = (pref_hash[k] * Base + cur_text[k % n]) % Modulus;
      base_pow[k+1] = (base_pow[k] * Base) % Modulus;
    end
    best = 0;
    for (cand = 1; cand < n; cand++) begin
      lo = 1;
      hi = n;
      common = 0;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (window_of(best, mid) == window_of(cand, mid)) begin
          common = mid;
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      if (cur_text[(best + common) % n] > cur_text[(cand + common) % n]) best = cand;
    end
    res.start_index = best[9:0];
    res.text_length = n[10:0];
    return res;
  endfunction

  // Track one accepted byte; queue a result on the final one
  function automatic void absorb_beat(in_item_t it);
    out_item_t res;
    if (cur_text.size() < StoreDepth) cur_text.insert(cur_text.size(), it.char_value);
    if (it.is_final) begin
      res = least_rotation();
      if (typed_pending) res = typed_result;
      rotation_q.insert(rotation_q.size(), res);
      cur_text.delete();
      string_cnt++;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, result_cnt);
    mismatch_cnt++;
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (rotation_q.size() == 0) begin
        report_mismatch("unexpected result, start", out_data_o.start_index, 0);
      end else begin
        if (out_data_o.start_index !== rotation_q[0].start_index)
          report_mismatch("start_index", out_data_o.start_index, rotation_q[0].start_index);
        if (out_data_o.text_length !== rotation_q[0].text_length)
          report_mismatch("text_length", out_data_o.text_length, rotation_q[0].text_length);
        void'(rotation_q.pop_front());
      end
      result_cnt++;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    pop <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
  end

  // Drive one beat, idling first at random; push stays high into the next beat
  task automatic send_beat(logic [7:0] ch, logic fin);
    in_item_t it;
    it.char_value = ch;
    it.is_final = fin;
    while (!quiet && $urandom_range(99) < 25) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    absorb_beat(it);
    beat_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_string(int unsigned len, int unsigned alpha);
    int unsigned k;
    logic [7:0] ch;
    for (k = 0; k < len; k++) begin
      ch = (alpha == 0) ? 8'($urandom_range(255)) : 8'(8'h61 + $urandom_range(alpha - 1));
      send_beat(ch, k == len - 1);
    end
  endtask

  initial begin
    dir_row_t rows[23];
    int unsigned i, len;
    rows = '{
      '{8'h00, 1'b1, 1'b1, 10'd0, 11'd1},
      '{8'hff, 1'b1, 1'b1, 10'd0, 11'd1},
      '{8'h62, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h61, 1'b1, 1'b1, 10'd1, 11'd2},
      '{8'hff, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h00, 1'b1, 1'b1, 10'd1, 11'd2},
      '{8'h00, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'hff, 1'b1, 1'b1, 10'd0, 11'd2},
      '{8'h61, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h61, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h61, 1'b1, 1'b1, 10'd0, 11'd3},
      '{8'h63, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h61, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h62, 1'b1, 1'b1, 10'd1, 11'd3},
      '{8'h62, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h61, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h62, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h61, 1'b1, 1'b1, 10'd1, 11'd4},
      '{8'h55, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'haa, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h00, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'h55, 1'b0, 1'b0, 10'd0, 11'd0},
      '{8'haa, 1'b1, 1'b0, 10'd0, 11'd0}
    };
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed strings: single bytes, extremes, ties
    foreach (rows[i]) begin
      typed_pending = rows[i].typed;
      typed_result.start_index = rows[i].exp_start;
      typed_result.text_length = rows[i].exp_len;
      send_beat(rows[i].ch, rows[i].fin);
    end
    typed_pending = 1'b0;

    // Hold off until every directed result has drained
    push <= 1'b0;
    while (rotation_q.size() != 0) @(negedge clk_i);

    // Random strings, mostly short over small alphabets
    for (i = 0; i < NumStrings; i++) begin
      quiet = (i >= 40 && i < 55);
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
      send_string(len, $urandom_range(3));
    end
    quiet = 1'b0;

    // One string over the full byte range
    send_string(5, 0);

    push <= 1'b0;
    while (rotation_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d byte beats in %0d strings, %0d results checked", beat_cnt, string_cnt,
             result_cnt);
    $display("covered ties, extreme bytes, a drain pause and a stretch with no stalls");
    if (mismatch_cnt == 0 && rotation_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/mrhs_pkg.sv
hw/rtl/mrhs_front.sv
hw/rtl/mrhs_engine.sv
hw/rtl/minimal_rotation_by_hash_search.sv
tb/testbench.sv
